// File: rtl/htw_pkg.sv
// Package for the hierarchical timer wheel: operation codes, sweep states,
// fixed field widths and the control bundle to the slot update unit.
// No dependencies.
package htw_pkg;

    localparam int TIME_W  = 48;
    localparam int LEVEL_W = 3;
    localparam int OP_W    = 2;
    localparam int ID_W    = 6;
    localparam int DELAY_W = 32;

    localparam logic [OP_W-1:0] OP_ARM    = 2'd0;
    localparam logic [OP_W-1:0] OP_DISARM = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SWEEP,
        ST_FLUSH
    } htw_state_t;

    typedef struct packed {
        logic tick;
        logic arm;
        logic disarm;
        logic match;
    } htw_ctl_t;

endpackage

// File: rtl/htw_cell.sv
// One storage cell of the slot ring: holds one packed slot entry and takes
// its neighbor's entry on each shift. Depends on nothing.
module htw_cell #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         shift,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else if (shift)
        begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule

// File: rtl/htw_div.sv
// Divide by the constant tick length with a reciprocal multiply; operand, product and quotient are registered in turn.
// Depends on htw_pkg.
module htw_div
    import htw_pkg::*;
#(
    parameter int TICK_MS = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DELAY_W-1:0] dividend,
    output logic               done,
    output logic [DELAY_W-1:0] quotient,
    output logic               rem_zero
);

    // Rounded-up reciprocal: exact for every 32-bit dividend, at most 33 bits wide.
    localparam int                 SH       = DELAY_W + $clog2(TICK_MS);
    localparam logic [63:0]        MAGIC    = ((64'd1 << SH) + 64'(TICK_MS) - 64'd1) /
                                              64'(TICK_MS);
    localparam logic               MAGIC_HI = MAGIC[DELAY_W];
    localparam logic [DELAY_W-1:0] MAGIC_LO = MAGIC[DELAY_W-1:0];

    logic                   s1_reg, s1_next;
    logic                   s2_reg, s2_next;
    logic                   done_reg, done_next;
    logic [DELAY_W-1:0]     x_reg, x_next;
    logic [2*DELAY_W:0]     prod_reg, prod_next;
    logic [DELAY_W-1:0]     quo_reg, quo_next;
    logic [2*DELAY_W-1:0]   lo_prod;
    logic [DELAY_W-1:0]     back;

    always_comb
    begin
        lo_prod   = (2*DELAY_W)'(x_reg) * (2*DELAY_W)'(MAGIC_LO);
        s1_next   = start;
        s2_next   = s1_reg;
        done_next = s2_reg;
        x_next    = x_reg;
        prod_next = prod_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            x_next = dividend;
        end
        if (s1_reg)
        begin
            prod_next = {1'b0, lo_prod} +
                        (MAGIC_HI ? {1'b0, x_reg, {DELAY_W{1'b0}}} : '0);
        end
        if (s2_reg)
        begin
            quo_next = DELAY_W'(prod_reg >> SH);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg   <= 1'b0;
            s2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            s1_reg   <= s1_next;
            s2_reg   <= s2_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        prod_reg <= prod_next;
        quo_reg  <= quo_next;
    end

    // quotient times divisor never exceeds the dividend, so the low bits suffice
    assign back     = DELAY_W'((2*DELAY_W)'(quo_reg) * (2*DELAY_W)'(TICK_MS));
    assign done     = done_reg;
    assign quotient = quo_reg;
    assign rem_zero = (back == x_reg);

endmodule

// File: rtl/htw_place.sv
// Slot update unit at the head of the ring: expiry, cascade, placement and disarm of
// the entry passing by. Depends on htw_pkg.
module htw_place
    import htw_pkg::*;
#(
    parameter int FIRST_LEVEL_BITS = 8,
    parameter int UPPER_LEVEL_BITS = 6,
    parameter int LEVELS           = 5,
    parameter int SPW              = 8,
    parameter int EW               = 1 + LEVEL_W + SPW + TIME_W + 1
) (
    input  htw_ctl_t                                   ctl,
    input  logic [EW-1:0]                              entry_in,
    input  logic [DELAY_W-1:0]                         q_in,
    input  logic                                       q_rz,
    input  logic [TIME_W-1:0]                          tcount,
    input  logic [TIME_W-1:0]                          tcount_new,
    input  logic [FIRST_LEVEL_BITS-1:0]                f_old,
    input  logic [FIRST_LEVEL_BITS-1:0]                f_use,
    input  logic [LEVELS-2:0][UPPER_LEVEL_BITS-1:0]    upos_old,
    input  logic [LEVELS-2:0][UPPER_LEVEL_BITS-1:0]    upos_use,
    input  logic [LEVELS-2:0]                          casc,
    output logic [EW-1:0]                              entry_out,
    output logic                                       hit
);

    localparam int FB = FIRST_LEVEL_BITS;
    localparam int UB = UPPER_LEVEL_BITS;

    logic               armed, rz;
    logic [LEVEL_W-1:0] lvl;
    logic [SPW-1:0]     spk;
    logic [TIME_W-1:0]  dt;
    logic [TIME_W-1:0]  diff;
    logic [DELAY_W-1:0] iv;
    logic               dead, l0_hit, casc_hit;
    logic [LEVEL_W-1:0] p_lvl;
    logic [SPW-1:0]     p_spk;

    assign {armed, lvl, spk, dt, rz} = entry_in;
    assign diff = dt - tcount_new;
    assign dead = (dt < tcount_new) || ((dt == tcount_new) && rz);
    assign iv   = ctl.arm ? q_in : diff[DELAY_W-1:0];

    // level and spoke for a remaining interval in ticks
    always_comb
    begin
        logic        found;
        logic [63:0] idx;
        found = 1'b0;
        idx   = '0;
        p_lvl = '0;
        p_spk = SPW'(FB'(iv[FB-1:0] + f_use));
        if ((64'(iv) >> FB) != 64'd0)
        begin
            for (int k = 1; k < LEVELS; k++)
            begin
                if (!found && ((k == LEVELS - 1) ||
                    ((64'(iv) >> (FB + k * UB)) == 64'd0)))
                begin
                    idx   = (64'(iv) >> (FB + (k - 1) * UB)) - 64'd1 + 64'(upos_use[k-1]);
                    p_lvl = LEVEL_W'(k);
                    p_spk = SPW'(idx[UB-1:0]);
                    found = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        casc_hit = 1'b0;
        for (int k = 1; k < LEVELS; k++)
        begin
            if (lvl == LEVEL_W'(k) && casc[k-1] && spk == SPW'(upos_old[k-1]))
            begin
                casc_hit = 1'b1;
            end
        end
    end

    assign l0_hit = (lvl == '0) && (spk == SPW'(f_old));

    always_comb
    begin
        logic               armed_n, rz_n;
        logic [LEVEL_W-1:0] lvl_n;
        logic [SPW-1:0]     spk_n;
        logic [TIME_W-1:0]  dt_n;
        armed_n = armed;
        rz_n    = rz;
        lvl_n   = lvl;
        spk_n   = spk;
        dt_n    = dt;
        hit     = 1'b0;
        if (ctl.tick)
        begin
            if (armed && l0_hit)
            begin
                hit     = 1'b1;
                armed_n = 1'b0;
            end
            else if (armed && casc_hit)
            begin
                if (dead)
                begin
                    hit     = 1'b1;
                    armed_n = 1'b0;
                end
                else
                begin
                    lvl_n = p_lvl;
                    spk_n = p_spk;
                end
            end
        end
        else if (ctl.arm && ctl.match)
        begin
            armed_n = 1'b1;
            lvl_n   = p_lvl;
            spk_n   = p_spk;
            dt_n    = tcount + TIME_W'(q_in);
            rz_n    = q_rz;
        end
        else if (ctl.disarm && ctl.match)
        begin
            armed_n = 1'b0;
        end
        entry_out = {armed_n, lvl_n, spk_n, dt_n, rz_n};
    end

endmodule

// File: rtl/hierarchical_timer_wheel.sv
// Hierarchical timer wheel: a ring of SLOTS cells rotates once per item past one update unit.
// Arm runs the reciprocal divide, then a full rotation; disarm takes a full rotation;
// tick takes a full rotation and a flush of the held expiry, and out_ready stalls can hold it.
// Throughput: one item per rotation; the single update unit at the ring head sets the rate.
// Reset: every slot disarmed, wheel positions and tick count zero; no clearing pass.
// Depends on htw_pkg, htw_cell, htw_div and htw_place.
module hierarchical_timer_wheel
    import htw_pkg::*;
#(
    parameter int SLOTS            = 64,
    parameter int TICK_MS          = 10,
    parameter int FIRST_LEVEL_BITS = 8,
    parameter int UPPER_LEVEL_BITS = 6,
    parameter int LEVELS           = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [OP_W-1:0]    op,
    input  logic [ID_W-1:0]    timer_id,
    input  logic [DELAY_W-1:0] delay_ms,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [ID_W-1:0]    expired_id,
    output logic               last
);

    localparam int FB  = FIRST_LEVEL_BITS;
    localparam int UB  = UPPER_LEVEL_BITS;
    localparam int SPW = (FB > UB) ? FB : UB;
    localparam int EW  = 1 + LEVEL_W + SPW + TIME_W + 1;
    localparam int CW  = $clog2(SLOTS);

    // Sweep control and the item under work.
    htw_state_t  state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [OP_W-1:0] op_reg, op_next;
    logic [ID_W-1:0] id_reg, id_next;

    // Wheel time: tick count and positions of every level.
    logic [TIME_W-1:0] tcount_reg, tcount_next, tcount_new;
    logic [FB-1:0]     fpos_reg, fpos_next, f_new, f_use;
    logic [LEVELS-2:0][UB-1:0] upos_reg, upos_next, upos_new, upos_use;
    logic [LEVELS-2:0] casc;

    // Held expiry: one result waits here until the next one shows whether it is last.
    logic          pend_v_reg, pend_v_next;
    logic [CW-1:0] pend_id_reg, pend_id_next;

    // Output register.
    logic            out_valid_reg, out_valid_next;
    logic [ID_W-1:0] out_id_reg, out_id_next;
    logic            out_last_reg, out_last_next;

    logic               div_start, div_done, div_rz;
    logic [DELAY_W-1:0] div_q;
    htw_ctl_t           ctl;
    logic [EW-1:0]      ring [SLOTS];
    logic [EW-1:0]      head_out;
    logic               hit, out_free, stall, shift;

    htw_div #(
        .TICK_MS (TICK_MS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (delay_ms),
        .done     (div_done),
        .quotient (div_q),
        .rem_zero (div_rz)
    );

    // The ring: cell 0 is the head; the updated head entry enters at the tail, so
    // after SLOTS shifts every slot sits in its home cell again.
    genvar g;
    generate
        for (g = 0; g < SLOTS; g++)
        begin : g_ring
            if (g == SLOTS - 1)
            begin : g_tail
                htw_cell #(.W(EW)) u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (shift),
                    .d     (head_out),
                    .q     (ring[g])
                );
            end
            else
            begin : g_body
                htw_cell #(.W(EW)) u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (shift),
                    .d     (ring[g+1]),
                    .q     (ring[g])
                );
            end
        end
    endgenerate

    // Positions after this tick: advance level 0, carry into upper levels on wrap.
    always_comb
    begin
        f_new   = fpos_reg + 1'b1;
        casc[0] = (f_new == '0);
        for (int k = 1; k < LEVELS - 1; k++)
        begin
            casc[k] = casc[k-1] && (UB'(upos_reg[k-1] + 1'b1) == '0);
        end
        for (int k = 0; k < LEVELS - 1; k++)
        begin
            upos_new[k] = casc[k] ? UB'(upos_reg[k] + 1'b1) : upos_reg[k];
        end
    end

    assign tcount_new = tcount_reg + 1'b1;
    assign ctl.tick   = (op_reg == OP_TICK);
    assign ctl.arm    = (op_reg == OP_ARM);
    assign ctl.disarm = (op_reg == OP_DISARM);
    assign ctl.match  = (32'(cnt_reg) == 32'(id_reg));
    assign f_use      = ctl.tick ? f_new : fpos_reg;
    assign upos_use   = ctl.tick ? upos_new : upos_reg;

    htw_place #(
        .FIRST_LEVEL_BITS (FB),
        .UPPER_LEVEL_BITS (UB),
        .LEVELS           (LEVELS),
        .SPW              (SPW),
        .EW               (EW)
    ) u_place (
        .ctl        (ctl),
        .entry_in   (ring[0]),
        .q_in       (div_q),
        .q_rz       (div_rz),
        .tcount     (tcount_reg),
        .tcount_new (tcount_new),
        .f_old      (fpos_reg),
        .f_use      (f_use),
        .upos_old   (upos_reg),
        .upos_use   (upos_use),
        .casc       (casc),
        .entry_out  (head_out),
        .hit        (hit)
    );

    // Hold the ring when a second expiry arrives and the output register is still full.
    assign out_free = !out_valid_reg || out_ready;
    assign stall    = hit && pend_v_reg && !out_free;
    assign shift    = (state_reg == ST_SWEEP) && !stall;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        tcount_next    = tcount_reg;
        fpos_next      = fpos_reg;
        upos_next      = upos_reg;
        pend_v_next    = pend_v_reg;
        pend_id_next   = pend_id_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_id_next    = out_id_reg;
        out_last_next  = out_last_reg;
        in_ready       = 1'b0;
        div_start      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next  = op;
                    id_next  = timer_id;
                    cnt_next = '0;
                    case (op)
                        OP_ARM:
                        begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                        OP_DISARM, OP_TICK:
                        begin
                            state_next = ST_SWEEP;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (!stall)
                begin
                    if (hit)
                    begin
                        pend_v_next  = 1'b1;
                        pend_id_next = cnt_reg;
                        if (pend_v_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_id_next    = ID_W'(pend_id_reg);
                            out_last_next  = 1'b0;
                        end
                    end
                    if (cnt_reg == CW'(SLOTS - 1))
                    begin
                        if (ctl.tick)
                        begin
                            tcount_next = tcount_new;
                            fpos_next   = f_new;
                            upos_next   = upos_new;
                            state_next  = ST_FLUSH;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                // drain the held expiry as the last one of this tick
                if (!pend_v_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_id_next    = ID_W'(pend_id_reg);
                    out_last_next  = 1'b1;
                    pend_v_next    = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            tcount_reg    <= '0;
            fpos_reg      <= '0;
            upos_reg      <= '0;
            pend_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            tcount_reg    <= tcount_next;
            fpos_reg      <= fpos_next;
            upos_reg      <= upos_next;
            pend_v_reg    <= pend_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        id_reg       <= id_next;
        pend_id_reg  <= pend_id_next;
        out_id_reg   <= out_id_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign expired_id = out_id_reg;
    assign last       = out_last_reg;

`ifndef SYNTH
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_v_reg)
        else $error("held expiry left over in idle");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    a_stall_holds_ring: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SWEEP) && stall) |=> ((state_reg == ST_SWEEP) && $stable(cnt_reg)))
        else $error("ring advanced during output stall");
`endif

endmodule

// File: tb/tb_hierarchical_timer_wheel.sv
// Self-checking testbench for the hierarchical timer wheel: arm, disarm and tick
// transfers against an in-bench wheel predictor, with random idle and stall phases.
// Depends on htw_pkg and hierarchical_timer_wheel.
module tb_hierarchical_timer_wheel;
    import htw_pkg::*;

    localparam int SLOTS       = 64;
    localparam int TICK_MS     = 10;
    localparam int FIRST_BITS  = 8;
    localparam int UPPER_BITS  = 6;
    localparam int LEVELS      = 5;
    localparam int WAIT_CYCLES = 64;
    localparam int LIMIT       = 1000000;
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [ID_W-1:0]    id;
        logic [DELAY_W-1:0] delay;
    } wheel_cmd_t;

    typedef struct {
        logic [ID_W-1:0] id;
        logic            last;
    } expiry_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] timer_id;
    logic [DELAY_W-1:0] delay_ms;
    logic out_valid;
    logic out_ready;
    logic [ID_W-1:0] expired_id;
    logic last;

    hierarchical_timer_wheel u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .timer_id   (timer_id),
        .delay_ms   (delay_ms),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .expired_id (expired_id),
        .last       (last)
    );

    // Predictor state: a private copy of the wheel
    logic        armed [SLOTS];
    logic [47:0] deadline [SLOTS];
    logic [2:0]  lvl [SLOTS];
    logic [7:0]  spoke [SLOTS];
    logic [7:0]  pos0;
    logic [5:0]  upos [LEVELS];
    logic [47:0] now_ms;

    wheel_cmd_t cmd_q[$];
    expiry_t    expiry_q[$];
    int errors;
    int cycles;
    int idle_pct;
    int stall_pct;
    int ticks_sent;
    int expiries_seen;

    // Place a slot on a level and spoke from its remaining time in ms.
    function automatic void place(int s, logic [31:0] ms);
        logic [63:0] ivl;
        logic [63:0] idx;
        int sh;
        ivl = ms / TICK_MS;
        if (ivl < (64'd1 << FIRST_BITS))
        begin
            lvl[s]   = 0;
            spoke[s] = 8'(ivl + pos0);
            return;
        end
        for (int k = 1; k < LEVELS; k++)
        begin
            sh = FIRST_BITS + (k - 1) * UPPER_BITS;
            if (k == LEVELS - 1 || ivl < (64'd1 << (sh + UPPER_BITS)))
            begin
                idx      = (ivl >> sh) - 1 + upos[k-1];
                lvl[s]   = 3'(k);
                spoke[s] = {2'b00, idx[5:0]};
                return;
            end
        end
    endfunction

    // Apply one accepted transfer and queue the expiries it causes.
    function automatic void apply_cmd(wheel_cmd_t c);
        logic hit [SLOTS];
        logic [5:0] cur;
        int lastn;
        if (c.op == OP_ARM)
        begin
            armed[c.id]    = 1'b1;
            deadline[c.id] = now_ms + c.delay;
            place(c.id, c.delay);
            return;
        end
        if (c.op == OP_DISARM)
        begin
            armed[c.id] = 1'b0;
            return;
        end
        if (c.op != OP_TICK)
            return;
        for (int i = 0; i < SLOTS; i++)
        begin
            hit[i] = armed[i] && lvl[i] == 0 && spoke[i] == pos0;
            if (hit[i])
                armed[i] = 1'b0;
        end
        now_ms = now_ms + TICK_MS;
        pos0   = pos0 + 1;
        if (pos0 == 0)
        begin
            for (int k = 1; k < LEVELS; k++)
            begin
                cur       = upos[k-1];
                upos[k-1] = cur + 1;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!armed[i] || lvl[i] != k || spoke[i] != {2'b00, cur})
                        continue;
                    if (deadline[i] <= now_ms)
                    begin
                        hit[i]   = 1'b1;
                        armed[i] = 1'b0;
                    end
                    else
                        place(i, 32'(deadline[i] - now_ms));
                end
                if (upos[k-1] != 0)
                    break;
            end
        end
        lastn = -1;
        for (int i = 0; i < SLOTS; i++)
            if (hit[i])
                lastn = i;
        for (int i = 0; i < SLOTS; i++)
            if (hit[i])
                expiry_q.push_back('{6'(i), i == lastn});
    endfunction

    function automatic void add(logic [OP_W-1:0] o, int id, logic [31:0] d);
        cmd_q.push_back('{o, 6'(id), d});
    endfunction

    // Push a run of ticks; the payload fields carry random noise.
    function automatic void add_ticks(int n);
        for (int i = 0; i < n; i++)
            add(OP_TICK, $urandom_range(0, 63), $urandom);
    endfunction

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // Driver: hold valid and payload until the transfer, then take the next item.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            op       <= OP_NONE;
            timer_id <= '0;
            delay_ms <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
                apply_cmd('{op, timer_id, delay_ms});
            if (cmd_q.size() > 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                wheel_cmd_t c;
                c = cmd_q.pop_front();
                in_valid <= 1'b1;
                op       <= c.op;
                timer_id <= c.id;
                delay_ms <= c.delay;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: compare each expiry transfer with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                expiries_seen++;
                if (expiry_q.size() == 0)
                begin
                    $display("%0t: unexpected expiry id=%0d last=%0b",
                             $time, expired_id, last);
                    errors++;
                end
                else
                begin
                    expiry_t e;
                    e = expiry_q.pop_front();
                    if (e.id !== expired_id || e.last !== last)
                    begin
                        $display("%0t: expected id=%0d last=%0b, got id=%0d last=%0b",
                                 $time, e.id, e.last, expired_id, last);
                        errors++;
                    end
                end
            end
            out_ready <= $urandom_range(0, 99) >= stall_pct;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // Wait until queued stimulus is taken and predictions drained, then settle.
    task automatic drain();
        while (cmd_q.size() > 0 || in_valid)
            @(posedge clk);
        while (expiry_q.size() > 0)
            @(posedge clk);
        repeat (WAIT_CYCLES * 2) @(posedge clk);
    endtask

    // One random phase: mostly arm/tick bursts that actually expire, plus noise.
    task automatic random_phase(int n, int idle, int stall);
        int r;
        idle_pct  = idle;
        stall_pct = stall;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                add(OP_ARM, $urandom_range(0, 63), $urandom_range(0, 60));
            else if (r < 48)
                add(OP_ARM, $urandom_range(0, 63), $urandom);
            else if (r < 58)
                add(OP_DISARM, $urandom_range(0, 63), $urandom);
            else if (r < 61)
                add(OP_NONE, $urandom_range(0, 63), $urandom);
            else
                add(OP_TICK, $urandom_range(0, 63), $urandom);
        end
        drain();
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        expiries_seen = 0;
        idle_pct = 0;
        stall_pct = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            armed[i] = 0;
            deadline[i] = 0;
            lvl[i] = 0;
            spoke[i] = 0;
        end
        for (int k = 0; k < LEVELS; k++)
            upos[k] = 0;
        pos0 = 0;
        now_ms = 0;
        rst_n = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;

        // Directed: zero delay expires on the next tick, several slots in one tick,
        // re-arm, disarm of armed and unarmed slots, unknown op, empty tick.
        add(OP_ARM, 0, 0);
        add(OP_ARM, 63, 9);
        add(OP_ARM, 5, 20);
        add(OP_ARM, 5, 10);
        add(OP_ARM, 7, 10);
        add(OP_DISARM, 7, 0);
        add(OP_DISARM, 40, 32'hFFFF_FFFF);
        add(OP_NONE, 63, 32'hFFFF_FFFF);
        add_ticks(3);
        add(OP_ARM, 1, 2559);
        add(OP_ARM, 2, 2560);
        add(OP_ARM, 3, 5000);
        add(OP_ARM, 4, 32'hFFFF_FFFF);
        add(OP_ARM, 6, 32'd655360);
        add(OP_ARM, 8, 32'd2621440 * 4);
        add(OP_TICK, 0, 0);
        drain();
        add(OP_DISARM, 4, 0);
        add(OP_DISARM, 6, 0);
        add(OP_DISARM, 8, 0);
        drain();

        random_phase(35, 0, 0);
        random_phase(35, 51, 0);
        random_phase(35, 0, 51);
        random_phase(35, 9, 9);

        $display("Covered %0d expiries over %0d ms of wheel time, with idle and stall phases",
                 expiries_seen, now_ms);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// File: files.f
rtl/htw_pkg.sv
rtl/htw_cell.sv
rtl/htw_div.sv
rtl/htw_place.sv
rtl/hierarchical_timer_wheel.sv
tb/tb_hierarchical_timer_wheel.sv
